/* hw/rtl/six_bit_block_dequantizer_unit_assert.svh */
// Assertion macros shared by the dequantizer RTL.
// No dependencies.
`ifndef SIX_BIT_BLOCK_DEQUANTIZER_UNIT_ASSERT_SVH
`define SIX_BIT_BLOCK_DEQUANTIZER_UNIT_ASSERT_SVH

// Check that an antecedent implies a consequent on the next cycle.
`define SBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Check that a condition always holds.
`define SBD_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

/* hw/rtl/sbd_pkg.sv */
// Package for the six-bit block dequantizer: word types, scale terms, constants.
// No dependencies.
package sbd_pkg;

  localparam int unsigned Lanes        = 4;
  localparam logic [5:0]  CodeOffset   = 6'd32;
  localparam logic [4:0]  HalfExpMax   = 5'h1F;

  typedef struct packed {
    logic [15:0] block_scale;
    logic signed [7:0] group_scale;
    logic [15:0] low_nibbles;
    logic [7:0]  high_pairs;
    logic        last_of_row;
  } in_word_t;

  typedef struct packed {
    logic [31:0] value_lane3;
    logic [31:0] value_lane2;
    logic [31:0] value_lane1;
    logic [31:0] value_lane0;
    logic        row_end;
  } out_word_t;

  // Shared scale terms, computed once per word and fed to every lane.
  typedef struct packed {
    logic [18:0] prod;   // mantissa times group magnitude
    logic        sign;   // block sign xor group sign
    logic [4:0]  hexp;   // biased half exponent, 0 means subnormal
    logic        bad;    // NaN or Inf block scale
  } scale_t;

endpackage

/* hw/rtl/sbd_lane.sv */
// One dequantizer lane: code times scale product, normalized to fp32 bits.
// Depends on sbd_pkg.
module sbd_lane (
  input  logic           clk_i,
  input  logic           en_i,
  input  sbd_pkg::scale_t scale_i,
  input  logic [3:0]     low_i,
  input  logic [1:0]     high_i,
  output logic [31:0]    value_o
);

  logic [5:0]  code;
  logic [5:0]  qmag;
  logic        qneg;
  logic [23:0] p;
  logic [4:0]  top;
  logic [7:0]  expf;
  logic [23:0] norm;
  logic        sign;
  logic [31:0] value_d, value_q;

  assign code = {high_i, low_i};
  assign qneg = code < sbd_pkg::CodeOffset;
  assign qmag = qneg ? (sbd_pkg::CodeOffset - code) : (code - sbd_pkg::CodeOffset);
  assign p    = {5'd0, scale_i.prod} * {18'd0, qmag};
  assign sign = scale_i.sign ^ qneg;

  // Find the leading one of the product.
  always_comb begin
    top = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (p[i]) top = 5'(i);
    end
  end

  // Pack sign, exponent and fraction; exponent = top + e + 127.
  always_comb begin
    norm = p << (5'd23 - top);
    if (scale_i.hexp == 5'd0) expf = 8'(top) + 8'd103;
    else expf = 8'(top) + 8'(scale_i.hexp) + 8'd102;
    if (scale_i.bad) value_d = 32'd0;
    else if (p == 24'd0) value_d = {sign, 31'd0};
    else value_d = {sign, expf, norm[22:0]};
  end

  // Hold the lane result.
  always_ff @(posedge clk_i) begin
    if (en_i) value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

/* hw/rtl/six_bit_block_dequantizer_unit.sv */
// Six-bit block dequantizer top: scale stage, parallel lanes, result merge.
// Depends on sbd_pkg, sbd_lane and the assertion macro header.
// Throughput one word per cycle; fire is registered into v1_q, then v2_q drives done_o.
// busy is held low: a word can start every cycle, results cannot be stalled.
// The lanes have one multiplier each, combinational, with the lane result registered.
// Reset (rst_ni low, asynchronous) clears the valid pipeline; no word pending.
`include "six_bit_block_dequantizer_unit_assert.svh"
module six_bit_block_dequantizer_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  sbd_pkg::in_word_t  data_i,
  output logic               done_o,
  output sbd_pkg::out_word_t data_o
);

  logic              fire;
  sbd_pkg::scale_t   scale_d, scale_q;
  logic [15:0]       lows_q;
  logic [7:0]        highs_q;
  logic              last_q, last2_q;
  logic              v1_q, v2_q;
  logic [10:0]       m;
  logic [7:0]        gmag;
  logic [sbd_pkg::Lanes*32-1:0] lane_vals;

  assign busy = 1'b0;
  assign fire = start && !busy;

  // Build the shared scale product.
  always_comb begin
    m = (data_i.block_scale[14:10] == 5'd0) ? {1'b0, data_i.block_scale[9:0]}
                                             : {1'b1, data_i.block_scale[9:0]};
    gmag = data_i.group_scale[7] ? (8'd0 - data_i.group_scale) : data_i.group_scale;
    scale_d.prod = {8'd0, m} * {11'd0, gmag};
    scale_d.sign = data_i.block_scale[15] ^ data_i.group_scale[7];
    scale_d.hexp = data_i.block_scale[14:10];
    scale_d.bad  = data_i.block_scale[14:10] == sbd_pkg::HalfExpMax;
  end

  // Advance the valid pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= fire;
      v2_q <= v1_q;
    end
  end

  // Hold the stage-one payload.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      scale_q <= scale_d;
      lows_q  <= data_i.low_nibbles;
      highs_q <= data_i.high_pairs;
      last_q  <= data_i.last_of_row;
    end
    if (v1_q) last2_q <= last_q;
  end

  for (genvar n = 0; n < sbd_pkg::Lanes; n++) begin : g_lane
    sbd_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (v1_q),
      .scale_i(scale_q),
      .low_i  (lows_q[4*n +: 4]),
      .high_i (highs_q[2*n +: 2]),
      .value_o(lane_vals[32*n +: 32])
    );
  end

  // Merge lane results into the output word.
  always_comb begin
    data_o.value_lane0 = lane_vals[31:0];
    data_o.value_lane1 = lane_vals[63:32];
    data_o.value_lane2 = lane_vals[95:64];
    data_o.value_lane3 = lane_vals[127:96];
    data_o.row_end     = last2_q;
  end
  assign done_o = v2_q;

  `SBD_ASSERT_NEXT(a_fire_valid, clk_i, rst_ni, fire, v1_q, "stage one lost a word")
  `SBD_ASSERT_NEXT(a_done_follows, clk_i, rst_ni, v1_q, done_o, "result strobe missing")
  `SBD_ASSERT_ALWAYS(a_bad_zero, clk_i, rst_ni,
    !(done_o && $past(scale_q.bad, 1) && $past(v1_q, 1)) || data_o.value_lane0 == 32'd0,
    "bad scale gave nonzero")

endmodule
